// File: sv/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// shared types and constants of the counting bloom filter
// ----------------------------------------------------------------------------
`default_nettype none
package cbf_pkg;
  localparam int HASH_W = 32;
  localparam int CNT_W  = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'hf;

  localparam int MAX_FUNCS             = 8;
  localparam int MAX_COUNTERS_PER_FUNC = 4096;
  localparam int STORE_DEPTH           = MAX_FUNCS * MAX_COUNTERS_PER_FUNC;
  // counter store address, region size and lane number widths
  localparam int SW      = $clog2(STORE_DEPTH);
  localparam int CPF_W   = 13;
  localparam int FUNCS_W = 4;
  localparam int LANE_W  = $clog2(MAX_FUNCS);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_NUM_FUNCS = 2'd0,
    REG_COUNTS    = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_DIVIDE = 3'd2,
    ST_READ   = 3'd3,
    ST_WRITE  = 3'd4
  } state_t;
endpackage
`default_nettype wire

// File: sv/cbf_ram.sv
// ----------------------------------------------------------------------------
// cbf_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module cbf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/cbf_mod.sv
// ----------------------------------------------------------------------------
// cbf_mod
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module cbf_mod
  import cbf_pkg::*;
#(
  parameter int DW = 13
) (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] dividend,
  input  wire logic [DW-1:0]     divisor,
  output logic      [DW-1:0]     remainder
);
  localparam int BW = $clog2(HASH_W + 1);

  logic [HASH_W-1:0] shifter;
  logic [DW:0]       rem;
  logic [DW:0]       trial;
  logic [DW-1:0]     dvs;
  logic [BW-1:0]     bits_left;

  assign trial = {rem[DW-1:0], shifter[HASH_W-1]};

  // runs HASH_W steps after a start pulse, then holds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shifter   <= dividend;
      rem       <= '0;
      dvs       <= divisor;
      bits_left <= BW'(HASH_W);
    end else if (bits_left != '0) begin
      shifter   <= {shifter[HASH_W-2:0], 1'b0};
      bits_left <= bits_left - 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
      end else begin
        rem <= trial;
      end
    end
  end

  assign remainder = rem[DW-1:0];
endmodule
`default_nettype wire

// File: sv/cbf_lane.sv
// ----------------------------------------------------------------------------
// cbf_lane
// one hash function: reduce the hash and place it in its own counter region
// ----------------------------------------------------------------------------
`default_nettype none
module cbf_lane
  import cbf_pkg::*;
#(
  parameter int LANE = 0
) (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] hash,
  input  wire logic [CPF_W-1:0]  modulus,
  output logic      [SW-1:0]     addr
);
  logic [CPF_W-1:0] rem;

  cbf_mod #(.DW(CPF_W)) u_mod (
    .clk(clk), .start(start), .dividend(hash), .divisor(modulus),
    .remainder(rem)
  );

  // regions sit back to back, the base is the lane number times the region size
  assign addr = SW'(LANE) * SW'(modulus) + SW'(rem);
endmodule
`default_nettype wire

// File: sv/counting_bloom_filter.sv
// ----------------------------------------------------------------------------
// counting_bloom_filter
// counting bloom filter with 4-bit counters, one lane per hash function
// ----------------------------------------------------------------------------
// Every lane runs a bit-serial 32-bit remainder of its hash against the region
// size, all side by side in the divide state; then the lanes in use (one to
// eight) take turns on the shared counter ram with a read-modify-write each, a
// read state then a write state, and the last write registers the merged
// flags. The next request can be taken in the same cycle as the result
// appears. After reset a clearing pass zeroes all 32768 counters of the ram
// before the first request is taken. A result held by out_stall blocks the
// next request. Config writes belong in gaps with no request in flight.
`default_nettype none
module counting_bloom_filter
  import cbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [12:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [HASH_W-1:0] hash_0,
  input  wire logic [HASH_W-1:0] hash_1,
  input  wire logic [HASH_W-1:0] hash_2,
  input  wire logic [HASH_W-1:0] hash_3,
  input  wire logic [HASH_W-1:0] hash_4,
  input  wire logic [HASH_W-1:0] hash_5,
  input  wire logic [HASH_W-1:0] hash_6,
  input  wire logic [HASH_W-1:0] hash_7,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   present,
  output logic                   overflow_seen,
  output logic                   underflow_seen,
  output logic [HASH_W-1:0]      element_count
);
  localparam int STEP_W = $clog2(HASH_W);

  logic [FUNCS_W-1:0] num_funcs;
  logic [CPF_W-1:0]   region_len;
  logic [FUNCS_W-1:0] lanes_eff;
  logic [CPF_W-1:0]   cpf_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_funcs  <= 4'd7;
      region_len <= 13'd4096;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_NUM_FUNCS)) begin
        num_funcs <= cfg_data[FUNCS_W-1:0];
      end else begin
        region_len <= cfg_data;
      end
    end
  end

  always_comb begin
    lanes_eff = num_funcs;
    if (num_funcs == '0) lanes_eff = 4'd1;
    if (32'(num_funcs) > MAX_FUNCS) lanes_eff = 4'(MAX_FUNCS);
    cpf_eff = region_len;
    if (region_len == '0) cpf_eff = CPF_W'(1);
    if (32'(region_len) > MAX_COUNTERS_PER_FUNC)
      cpf_eff = CPF_W'(MAX_COUNTERS_PER_FUNC);
  end

  state_t            state, state_next;
  logic [SW-1:0]     clr_addr;
  logic [STEP_W-1:0] step;
  logic [LANE_W-1:0] lane_sel;
  action_t           act;
  logic              any_zero, any_full;
  logic [HASH_W-1:0] total;
  logic              accept, last_lane, lane_zero, lane_full;
  logic              ram_we;
  logic [SW-1:0]     ram_addr;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;
  logic [HASH_W-1:0] hash_in [MAX_FUNCS];
  logic [SW-1:0]     lane_addr [MAX_FUNCS];

  assign hash_in[0] = hash_0;
  assign hash_in[1] = hash_1;
  assign hash_in[2] = hash_2;
  assign hash_in[3] = hash_3;
  assign hash_in[4] = hash_4;
  assign hash_in[5] = hash_5;
  assign hash_in[6] = hash_6;
  assign hash_in[7] = hash_7;

  // all lanes reduce their hash at once, unused lanes are simply not walked
  for (genvar g = 0; g < MAX_FUNCS; g++) begin : g_lane
    cbf_lane #(.LANE(g)) u_lane (
      .clk(clk), .start(accept), .hash(hash_in[g]), .modulus(cpf_eff),
      .addr(lane_addr[g])
    );
  end

  cbf_ram #(.WIDTH(CNT_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign accept    = in_valid && !in_stall;
  assign lane_zero = (ram_rdata == '0);
  assign lane_full = (ram_rdata == CNT_MAX);
  assign last_lane = (FUNCS_W'(lane_sel) == lanes_eff - 4'd1);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_DIVIDE;
      ST_DIVIDE: if (step == STEP_W'(HASH_W - 1)) state_next = ST_READ;
      ST_READ:   state_next = ST_WRITE;
      ST_WRITE:  state_next = last_lane ? ST_IDLE : ST_READ;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_addr  = lane_addr[lane_sel];
    ram_wdata = ram_rdata;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = out_valid && out_stall;
      end
      ST_WRITE: begin
        case (act)
          ACT_ADD: begin
            ram_wdata = ram_rdata + CNT_W'(1);
            ram_we    = !lane_full;
          end
          ACT_REMOVE: begin
            ram_wdata = ram_rdata - CNT_W'(1);
            ram_we    = !lane_zero;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      step           <= '0;
      lane_sel       <= '0;
      act            <= ACT_NONE;
      any_zero       <= 1'b0;
      any_full       <= 1'b0;
      total          <= '0;
      out_valid      <= 1'b0;
      present        <= 1'b0;
      overflow_seen  <= 1'b0;
      underflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (accept) begin
        step     <= '0;
        lane_sel <= '0;
        act      <= action_t'(action);
        any_zero <= 1'b0;
        any_full <= 1'b0;
      end
      if (state == ST_DIVIDE) step <= step + 1'b1;
      if (state == ST_WRITE) begin
        any_zero <= any_zero || lane_zero;
        any_full <= any_full || lane_full;
        lane_sel <= lane_sel + 1'b1;
      end
      // merge the lanes on the last write
      if (state == ST_WRITE && last_lane) begin
        out_valid      <= 1'b1;
        present        <= (act == ACT_CHECK) && !(any_zero || lane_zero);
        overflow_seen  <= (act == ACT_ADD) && (any_full || lane_full);
        underflow_seen <= (act == ACT_REMOVE) && (any_zero || lane_zero);
        if (act == ACT_ADD) total <= total + 32'd1;
        else if (act == ACT_REMOVE) total <= total - 32'd1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign element_count = total;
endmodule
`default_nettype wire

// File: sim/cbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_checker
// watches the request and result channels of the counting bloom filter,
// keeps its own copy of the counters and compares every result in order
// ----------------------------------------------------------------------------
module cbf_checker
  import cbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        action,
  input  logic [7:0][31:0]  hashes,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              present,
  input  logic              overflow_seen,
  input  logic              underflow_seen,
  input  logic [31:0]       element_count,
  output int                errors,
  output int                pending,
  output int                results_seen,
  output int                overflows_seen,
  output int                underflows_seen,
  output int                hits_seen
);
  localparam int LANES = 8;
  localparam int REGION = 4096;

  typedef struct packed {
    logic        present;
    logic        ovf;
    logic        unf;
    logic [31:0] count;
  } filter_result_t;

  logic [3:0]     counters [0:LANES*REGION-1];
  logic [31:0]    total;
  logic [3:0]     funcs_reg;
  logic [12:0]    region_reg;
  filter_result_t expected_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // apply one request to the counter copy and return what the block should say
  function automatic filter_result_t apply_request(input logic [1:0] act,
                                                   input logic [7:0][31:0] h);
    filter_result_t r;
    int unsigned lanes, cpf, idx;
    logic [3:0] c;
    logic all_set;
    lanes = (funcs_reg == 0) ? 1 : (funcs_reg > LANES) ? LANES : funcs_reg;
    cpf = (region_reg == 0) ? 1 : (region_reg > REGION) ? REGION : region_reg;
    r = '0;
    all_set = 1'b1;
    for (int i = 0; i < lanes; i++) begin
      idx = i * cpf + (h[i] % cpf);
      c = counters[idx];
      case (action_t'(act))
        ACT_ADD: begin
          if (c == CNT_MAX) r.ovf = 1'b1;
          else counters[idx] = c + 4'd1;
        end
        ACT_REMOVE: begin
          if (c == 4'd0) r.unf = 1'b1;
          else counters[idx] = c - 4'd1;
        end
        ACT_CHECK: begin
          if (c == 4'd0) all_set = 1'b0;
        end
        default: ;
      endcase
    end
    if (action_t'(act) == ACT_ADD) total = total + 1;
    else if (action_t'(act) == ACT_REMOVE) total = total - 1;
    r.present = (action_t'(act) == ACT_CHECK) ? all_set : 1'b0;
    r.count = total;
    return r;
  endfunction

  always @(posedge clk) begin
    filter_result_t want;
    if (rst) begin
      for (int i = 0; i < LANES*REGION; i++) counters[i] = '0;
      total = '0;
      funcs_reg = 4'd7;
      region_reg = 13'd4096;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(REG_NUM_FUNCS)) funcs_reg = cfg_data[3:0];
        else region_reg = cfg_data;
      end
      if (in_valid && !in_stall) expected_q.push_back(apply_request(action, hashes));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (overflow_seen) overflows_seen++;
        if (underflow_seen) underflows_seen++;
        if (present) hits_seen++;
        if (expected_q.size() == 0) begin
          report("result with nothing expected", 32'd0, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (present !== want.present)
            report("present", 32'(present), 32'(want.present));
          if (overflow_seen !== want.ovf)
            report("overflow_seen", 32'(overflow_seen), 32'(want.ovf));
          if (underflow_seen !== want.unf)
            report("underflow_seen", 32'(underflow_seen), 32'(want.unf));
          if (element_count !== want.count)
            report("element_count", element_count, want.count);
        end
      end
    end
    pending = expected_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    overflows_seen = 0;
    underflows_seen = 0;
    hits_seen = 0;
  end
endmodule

// File: sim/tb_counting_bloom_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_bloom_filter
// drives add, remove, check and unused-action requests through several filter setups with
// random idling and back-pressure; a separate checker predicts each result
// ----------------------------------------------------------------------------
module tb_counting_bloom_filter
  import cbf_pkg::*;
();
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PER_PHASE = 183;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [7:0][31:0] hashes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic present, overflow_seen, underflow_seen;
  logic [31:0] element_count;

  int errors, pending, results_seen, overflows_seen, underflows_seen, hits_seen;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int requests_sent = 0;
  int idle_cycles = 0;
  logic [31:0] key_pool [0:15][0:7];

  always #5 clk = ~clk;

  counting_bloom_filter uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .action,
    .hash_0(hashes[0]), .hash_1(hashes[1]), .hash_2(hashes[2]), .hash_3(hashes[3]),
    .hash_4(hashes[4]), .hash_5(hashes[5]), .hash_6(hashes[6]), .hash_7(hashes[7]),
    .out_valid, .out_stall, .present, .overflow_seen, .underflow_seen, .element_count
  );

  cbf_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall, .action, .hashes,
    .out_valid, .out_stall, .present, .overflow_seen, .underflow_seen, .element_count,
    .errors, .pending, .results_seen, .overflows_seen, .underflows_seen, .hits_seen
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input action_t act, input logic [7:0][31:0] h);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    hashes <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [12:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0][31:0] fill(input logic [31:0] w);
    logic [7:0][31:0] h;
    for (int i = 0; i < 8; i++) h[i] = w;
    return h;
  endfunction

  task automatic random_phase(input int n);
    logic [7:0][31:0] h;
    int k, roll;
    action_t act;
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(99);
      act = (roll < 45) ? ACT_ADD : (roll < 75) ? ACT_REMOVE : (roll < 95) ? ACT_CHECK : ACT_NONE;
      k = $urandom_range(15);
      if ($urandom_range(99) < 35) begin
        // fresh key, often kept for later removes and checks
        for (int i = 0; i < 8; i++) h[i] = $urandom();
        if ($urandom_range(1)) for (int i = 0; i < 8; i++) key_pool[k][i] = h[i];
      end else begin
        for (int i = 0; i < 8; i++) h[i] = key_pool[k][i];
      end
      send_request(act, h);
    end
  endtask

  initial begin
    for (int k = 0; k < 16; k++)
      for (int i = 0; i < 8; i++) key_pool[k][i] = $urandom();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty checks, extremes, underflow, unused action
    send_request(ACT_CHECK, fill(32'h0));
    send_request(ACT_REMOVE, fill(32'h0));
    send_request(ACT_ADD, fill(32'h0));
    send_request(ACT_CHECK, fill(32'h0));
    send_request(ACT_ADD, fill(32'hffff_ffff));
    send_request(ACT_CHECK, fill(32'hffff_ffff));
    send_request(ACT_NONE, fill(32'hffff_ffff));
    send_request(ACT_ADD, fill(32'h5555_5555));
    send_request(ACT_CHECK, fill(32'haaaa_aaaa));
    send_request(ACT_REMOVE, fill(32'hffff_ffff));
    send_request(ACT_REMOVE, fill(32'hffff_ffff));
    write_reg(REG_COUNTS, 13'd1);
    write_reg(REG_NUM_FUNCS, 13'd8);
    // saturate a single counter per lane
    for (int j = 0; j < 18; j++) send_request(ACT_ADD, fill($urandom()));
    send_request(ACT_CHECK, fill(32'h1234_5678));

    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd0);
    write_reg(REG_COUNTS, 13'd2);
    hold_req = 1'b1;
    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd15);
    write_reg(REG_COUNTS, 13'd8191);
    quiet = 1'b1;
    random_phase(PER_PHASE);
    quiet = 1'b0;
    write_reg(REG_NUM_FUNCS, 13'd1);
    write_reg(REG_COUNTS, 13'd0);
    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd3);
    write_reg(REG_COUNTS, 13'd3);
    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd8);
    write_reg(REG_COUNTS, 13'd4096);
    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd5);
    write_reg(REG_COUNTS, 13'd7);
    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd2);
    write_reg(REG_COUNTS, 13'd4097);
    random_phase(PER_PHASE);
    write_reg(REG_NUM_FUNCS, 13'd7);
    write_reg(REG_COUNTS, 13'd100);
    random_phase(PER_PHASE - 30);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results: %0d with overflow, %0d with underflow, %0d hits",
             requests_sent, results_seen, overflows_seen, underflows_seen, hits_seen);
    $display("setups covered 1 to 8 lanes and 1 to 4096 counters per lane");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/cbf_pkg.sv
sv/cbf_ram.sv
sv/cbf_mod.sv
sv/cbf_lane.sv
sv/counting_bloom_filter.sv
sim/cbf_checker.sv
sim/tb_counting_bloom_filter.sv
